// ----- hw/rtl/tdsc_pkg.sv -----
`default_nettype none
package tdsc_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DT_FRAC   = 32;

  localparam logic [62:0] SPRING_K_RST = 63'd5592047419392;
  localparam logic [62:0] CONTACT_RST  = 63'd5153960755;
  localparam logic [31:0] TIME_STEP_RST = 32'd42950;
  localparam logic [62:0] INV_MASS_RST = 63'd152055586173;
  localparam logic [15:0] REPORT_RST   = 16'd100;

  localparam logic [2:0] REG_SPRING_K  = 3'd0;
  localparam logic [2:0] REG_CONTACT   = 3'd1;
  localparam logic [2:0] REG_TIME_STEP = 3'd2;
  localparam logic [2:0] REG_INV_A     = 3'd3;
  localparam logic [2:0] REG_INV_B     = 3'd4;
  localparam logic [2:0] REG_REPORT    = 3'd5;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // scaling applied by the rounding stage
  localparam logic [1:0] SH_FB  = 2'd0;
  localparam logic [1:0] SH_DT  = 2'd1;
  localparam logic [1:0] SH_DT2 = 2'd2;

  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic [63:0] sat_sub64(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // round half away from zero, apply sign, saturate to signed 64 bits
  function automatic logic [63:0] round_sat(logic [127:0] p, logic [1:0] sel, logic neg);
    logic [128:0] sum;
    logic [128:0] shr;
    logic         ovf;
    case (sel)
      SH_FB: begin
        sum = {1'b0, p} + (129'd1 << (FRAC_BITS - 1));
        shr = sum >> FRAC_BITS;
      end
      SH_DT: begin
        sum = {1'b0, p} + (129'd1 << (DT_FRAC - 1));
        shr = sum >> DT_FRAC;
      end
      default: begin
        sum = {1'b0, p} + (129'd1 << DT_FRAC);
        shr = sum >> (DT_FRAC + 1);
      end
    endcase
    ovf = (|shr[128:64]) | shr[63];
    if (!neg) return ovf ? S64_MAX : shr[63:0];
    return ovf ? S64_MIN : (64'd0 - shr[63:0]);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/two_disk_spring_contact_step.sv -----
// Load item: taken straight from the idle state, no result.
// Advance item: the 64-step root, two 64-step divides (only with contact) and
// the products on one shared 32x32 multiplier set its duration; a reporting
// tick adds the two records on top.
// One item at a time.
// Reset (synchronous, rst_n low): state zero, countdown zero, registers default.
`default_nettype none
module two_disk_spring_contact_step
  import tdsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic        in_body,
  input  wire logic [63:0] in_load_pos_x,
  input  wire logic [63:0] in_load_pos_y,
  input  wire logic [63:0] in_load_vel_x,
  input  wire logic [63:0] in_load_vel_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_which_body,
  output logic [63:0]      out_pos_x,
  output logic [63:0]      out_pos_y,
  output logic [63:0]      out_vel_x,
  output logic [63:0]      out_vel_y,
  output logic [63:0]      out_acc_x,
  output logic [63:0]      out_acc_y,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [62:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_MAG  = 4'd2;
  localparam logic [3:0] ST_MLD  = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_SQRT = 4'd5;
  localparam logic [3:0] ST_CHK  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_RND  = 4'd8;
  localparam logic [3:0] ST_WB   = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;
  localparam logic [3:0] ST_OUT0 = 4'd11;
  localparam logic [3:0] ST_OUT1 = 4'd12;
  localparam logic [3:0] ST_VUP  = 4'd13;

  localparam logic [3:0] M_SQX = 4'd0;
  localparam logic [3:0] M_SQY = 4'd1;
  localparam logic [3:0] M_F   = 4'd2;
  localparam logic [3:0] M_FX  = 4'd3;
  localparam logic [3:0] M_FY  = 4'd4;
  localparam logic [3:0] M_AX0 = 4'd5;
  localparam logic [3:0] M_AY0 = 4'd6;
  localparam logic [3:0] M_AX1 = 4'd7;
  localparam logic [3:0] M_AY1 = 4'd8;
  localparam logic [3:0] M_TX  = 4'd9;
  localparam logic [3:0] M_TY  = 4'd10;
  localparam logic [3:0] M_VX  = 4'd11;
  localparam logic [3:0] M_VY  = 4'd12;
  localparam logic [3:0] M_PX  = 4'd13;
  localparam logic [3:0] M_PY  = 4'd14;

  logic [62:0] k_r, contact_r, inva_r, invb_r;
  logic [31:0] dt_r;
  logic [15:0] every_r, count_r;

  logic [63:0] px_r [2];
  logic [63:0] py_r [2];
  logic [63:0] vx_r [2];
  logic [63:0] vy_r [2];
  logic [63:0] ax_r [2];
  logic [63:0] ay_r [2];
  logic [63:0] tx_r [2];
  logic [63:0] ty_r [2];

  logic [3:0]   state_r, mop_r;
  logic         body_r;
  logic [5:0]   it_r;
  logic [63:0]  dx_r, dy_r, mdx_r, mdy_r, d_r, f_r, fx_r, fy_r, res_r;
  logic [127:0] acc_r;
  logic [67:0]  rem_r;
  logic [63:0]  opa_r, opb_r, prod_r;
  logic [1:0]   psh_r, sel_r;
  logic         neg_r;

  logic [63:0]  opa_nxt, opb_nxt;
  logic [1:0]   sel_nxt;
  logic         neg_nxt;

  // operand selection for the shared multiplier
  always_comb begin
    opa_nxt = 64'd0;
    opb_nxt = {32'd0, dt_r};
    sel_nxt = SH_FB;
    neg_nxt = 1'b0;
    case (mop_r)
      M_SQX: begin opa_nxt = mdx_r; opb_nxt = mdx_r; end
      M_SQY: begin opa_nxt = mdy_r; opb_nxt = mdy_r; end
      M_F:   begin opa_nxt = {1'b0, k_r}; opb_nxt = f_r; end
      M_FX:  begin opa_nxt = f_r; opb_nxt = mdx_r; end
      M_FY:  begin opa_nxt = f_r; opb_nxt = mdy_r; end
      M_AX0: begin opa_nxt = fx_r; opb_nxt = {1'b0, inva_r}; neg_nxt = ~dx_r[63]; end
      M_AY0: begin opa_nxt = fy_r; opb_nxt = {1'b0, inva_r}; neg_nxt = ~dy_r[63]; end
      M_AX1: begin opa_nxt = fx_r; opb_nxt = {1'b0, invb_r}; neg_nxt = dx_r[63]; end
      M_AY1: begin opa_nxt = fy_r; opb_nxt = {1'b0, invb_r}; neg_nxt = dy_r[63]; end
      M_TX: begin
        opa_nxt = mag64(ax_r[body_r]); neg_nxt = ax_r[body_r][63]; sel_nxt = SH_DT;
      end
      M_TY: begin
        opa_nxt = mag64(ay_r[body_r]); neg_nxt = ay_r[body_r][63]; sel_nxt = SH_DT;
      end
      M_VX: begin
        opa_nxt = mag64(vx_r[body_r]); neg_nxt = vx_r[body_r][63]; sel_nxt = SH_DT;
      end
      M_VY: begin
        opa_nxt = mag64(vy_r[body_r]); neg_nxt = vy_r[body_r][63]; sel_nxt = SH_DT;
      end
      M_PX: begin
        opa_nxt = mag64(tx_r[body_r]); neg_nxt = tx_r[body_r][63]; sel_nxt = SH_DT2;
      end
      M_PY: begin
        opa_nxt = mag64(ty_r[body_r]); neg_nxt = ty_r[body_r][63]; sel_nxt = SH_DT2;
      end
      default: ;
    endcase
  end

  logic [31:0]  mul_a, mul_b;
  logic [127:0] addend;
  logic [67:0]  rsh, trial;
  logic         sq_take;
  logic [63:0]  drem, drs;
  logic         dq;

  assign mul_a = it_r[0] ? opa_r[63:32] : opa_r[31:0];
  assign mul_b = it_r[1] ? opb_r[63:32] : opb_r[31:0];

  always_comb begin
    case (psh_r)
      2'd0:    addend = {64'd0, prod_r};
      2'd1:    addend = {32'd0, prod_r, 32'd0};
      default: addend = {prod_r, 64'd0};
    endcase
  end

  // one root bit per cycle
  assign rsh     = {rem_r[65:0], acc_r[127:126]};
  assign trial   = {2'b00, d_r, 2'b01};
  assign sq_take = (rsh >= trial);

  // one quotient bit per cycle; remainder lives in the upper half of acc
  assign drs  = {acc_r[126:64], acc_r[63]};
  assign dq   = acc_r[127] | (drs >= d_r);
  assign drem = dq ? (drs - d_r) : drs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= SPRING_K_RST;
      contact_r <= CONTACT_RST;
      dt_r      <= TIME_STEP_RST;
      inva_r    <= INV_MASS_RST;
      invb_r    <= INV_MASS_RST;
      every_r   <= REPORT_RST;
      count_r   <= 16'd0;
      state_r   <= ST_IDLE;
      mop_r     <= M_SQX;
      body_r    <= 1'b0;
      it_r      <= 6'd0;
      for (int i = 0; i < 2; i++) begin
        px_r[i] <= 64'd0;
        py_r[i] <= 64'd0;
        vx_r[i] <= 64'd0;
        vy_r[i] <= 64'd0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPRING_K:  k_r       <= cfg_wdata;
          REG_CONTACT:   contact_r <= cfg_wdata;
          REG_TIME_STEP: dt_r      <= cfg_wdata[31:0];
          REG_INV_A:     inva_r    <= cfg_wdata;
          REG_INV_B:     invb_r    <= cfg_wdata;
          REG_REPORT:    every_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!in_action) begin
              px_r[in_body] <= in_load_pos_x;
              py_r[in_body] <= in_load_pos_y;
              vx_r[in_body] <= in_load_vel_x;
              vy_r[in_body] <= in_load_vel_y;
            end else begin
              state_r <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          dx_r    <= sat_sub64(px_r[1], px_r[0]);
          dy_r    <= sat_sub64(py_r[1], py_r[0]);
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          mdx_r   <= mag64(dx_r);
          mdy_r   <= mag64(dy_r);
          mop_r   <= M_SQX;
          state_r <= ST_MLD;
        end
        ST_MLD: begin
          opa_r <= opa_nxt;
          opb_r <= opb_nxt;
          sel_r <= sel_nxt;
          neg_r <= neg_nxt;
          // squares of dx and dy sum in one accumulator
          if (mop_r != M_SQY) acc_r <= 128'd0;
          it_r    <= 6'd0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= mul_a * mul_b;
          psh_r  <= {1'b0, it_r[0]} + {1'b0, it_r[1]};
          if (it_r != 6'd0) acc_r <= acc_r + addend;
          it_r <= it_r + 6'd1;
          if (it_r == 6'd4) begin
            it_r <= 6'd0;
            case (mop_r)
              M_SQX: begin
                mop_r   <= M_SQY;
                state_r <= ST_MLD;
              end
              M_SQY: begin
                rem_r   <= 68'd0;
                d_r     <= 64'd0;
                state_r <= ST_SQRT;
              end
              M_FX, M_FY: state_r <= ST_DIV;
              default: state_r <= ST_RND;
            endcase
          end
        end
        ST_SQRT: begin
          rem_r <= sq_take ? (rsh - trial) : rsh;
          d_r   <= {d_r[62:0], sq_take};
          acc_r <= {acc_r[125:0], 2'b00};
          it_r  <= it_r + 6'd1;
          if (it_r == 6'd63) state_r <= ST_CHK;
        end
        ST_CHK: begin
          body_r <= 1'b0;
          if (d_r != 64'd0 && d_r < {1'b0, contact_r}) begin
            f_r   <= {1'b0, contact_r} - d_r;
            mop_r <= M_F;
          end else begin
            for (int i = 0; i < 2; i++) begin
              ax_r[i] <= 64'd0;
              ay_r[i] <= 64'd0;
            end
            mop_r <= M_TX;
          end
          state_r <= ST_MLD;
        end
        ST_DIV: begin
          acc_r <= {drem, acc_r[62:0], dq};
          it_r  <= it_r + 6'd1;
          if (it_r == 6'd63) begin
            if (mop_r == M_FX) begin
              fx_r  <= {acc_r[62:0], dq};
              mop_r <= M_FY;
            end else begin
              fy_r  <= {acc_r[62:0], dq};
              mop_r <= M_AX0;
            end
            state_r <= ST_MLD;
          end
        end
        ST_RND: begin
          res_r   <= round_sat(acc_r, sel_r, neg_r);
          state_r <= ST_WB;
        end
        ST_WB: begin
          case (mop_r)
            M_F:   f_r     <= res_r;
            M_AX0: ax_r[0] <= res_r;
            M_AY0: ay_r[0] <= res_r;
            M_AX1: ax_r[1] <= res_r;
            M_AY1: ay_r[1] <= res_r;
            M_TX:  tx_r[body_r] <= res_r;
            M_TY:  ty_r[body_r] <= res_r;
            M_VX, M_PX: px_r[body_r] <= sat_add64(px_r[body_r], res_r);
            M_VY, M_PY: py_r[body_r] <= sat_add64(py_r[body_r], res_r);
            default: ;
          endcase
          if (mop_r == M_PY) begin
            if (!body_r) begin
              body_r  <= 1'b1;
              mop_r   <= M_TX;
              state_r <= ST_MLD;
            end else begin
              state_r <= ST_FIN;
            end
          end else begin
            mop_r   <= mop_r + 4'd1;
            state_r <= ST_MLD;
          end
        end
        ST_FIN: begin
          if (count_r == 16'd0) begin
            count_r <= (every_r == 16'd0) ? 16'd0 : every_r - 16'd1;
            state_r <= ST_OUT0;
          end else begin
            count_r <= count_r - 16'd1;
            state_r <= ST_VUP;
          end
        end
        ST_OUT0: if (out_ready) state_r <= ST_OUT1;
        ST_OUT1: if (out_ready) state_r <= ST_VUP;
        ST_VUP: begin
          // records carry the old velocity, so advance it only now
          for (int i = 0; i < 2; i++) begin
            vx_r[i] <= sat_add64(vx_r[i], tx_r[i]);
            vy_r[i] <= sat_add64(vy_r[i], ty_r[i]);
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  logic ob;
  assign ob             = (state_r == ST_OUT1);
  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT0) || (state_r == ST_OUT1);
  assign out_which_body = ob;
  assign out_last       = ob;
  assign out_pos_x      = px_r[ob];
  assign out_pos_y      = py_r[ob];
  assign out_vel_x      = vx_r[ob];
  assign out_vel_y      = vy_r[ob];
  assign out_acc_x      = ax_r[ob];
  assign out_acc_y      = ay_r[ob];

endmodule
`default_nettype wire

// ----- hw/rtl/tdsc_checker.sv -----
`default_nettype none
module tdsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_which_body,
  input wire logic        out_last,
  input wire logic [63:0] out_pos_x
);

  // one item at a time: no input taken while a record is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a record is pending");

  // the record of A is followed at once by the record of B
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("second record of a tick missing");

  a_last_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_which_body))
    else $error("last flag does not match body");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x))
    else $error("stalled record changed");

endmodule

bind two_disk_spring_contact_step tdsc_checker u_tdsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_which_body (out_which_body),
  .out_last       (out_last),
  .out_pos_x      (out_pos_x)
);
`default_nettype wire
